// ----- hdl/cac_pkg.sv -----
// Shared constants for the clipped alpha compositor.
package cac_pkg;

    localparam int MAX_DIM      = 4096;
    localparam int FULL_SCALE   = 65025;            // 255 * 255
    localparam int DOUBLE_SCALE = 2 * FULL_SCALE;   // rounding divisor
    localparam int RECIP_SHIFT  = 32;
    // floor(2^32 / 130050); quotient from it is exact or one short
    localparam logic [15:0] RECIP =
        16'(64'h1_0000_0000 / 64'(DOUBLE_SCALE));

    localparam int NUM_LANES = 4;   // red, green, blue, alpha

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X      = 3'd0,
        REG_DEST_Y      = 3'd1,
        REG_CLIP_LEFT   = 3'd2,
        REG_CLIP_TOP    = 3'd3,
        REG_CLIP_WIDTH  = 3'd4,
        REG_CLIP_HEIGHT = 3'd5,
        REG_OPACITY     = 3'd6
    } cfg_reg_t;

endpackage

// ----- hdl/clipped_alpha_compose_top.sv -----
// Source-over RGBA blend with placement and clip, four-stage pipeline.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | 88-bit pixel pair and source position
//  m_      | out | m_tvalid/m_tready  | 56-bit blended pixel and position, flag
//  cfg_    | in  | cfg_valid/cfg_ready| register index and 13-bit value
//
// One word per clock while m_tready does not stall the pipe; an accepted word passes through every stage to m_tvalid.
// Stages: opacity*alpha and clip test, blend numerator, reciprocal multiply,
// remainder correction into the output register.
// aresetn is synchronous, active low; it clears the valid bits and loads the config defaults.
// A stall on m_tready freezes the whole pipe, bubbles included.
module clipped_alpha_compose_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // lsb up: src_red, src_green, src_blue, src_alpha,
    //         dst_red, dst_green, dst_blue, dst_alpha, src_col, src_row
    input  logic [87:0]                    s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // lsb up: out_red, out_green, out_blue, out_alpha, pos_x, pos_y
    output logic [55:0]                    m_tdata,
    // lsb up: write_enable
    output logic [0:0]                     m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cac_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cac_pkg::*;

    // configuration
    logic signed [12:0] dest_x_reg, dest_y_reg;
    logic [12:0]        clip_left_reg, clip_top_reg, clip_width_reg, clip_height_reg;
    logic [7:0]         opacity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_width_reg  <= 13'(MAX_DIM);
            clip_height_reg <= 13'(MAX_DIM);
            opacity_reg     <= 8'hff;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEST_X:      dest_x_reg      <= $signed(cfg_data);
                REG_DEST_Y:      dest_y_reg      <= $signed(cfg_data);
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data;
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data;
                REG_CLIP_WIDTH:  clip_width_reg  <= cfg_data;
                REG_CLIP_HEIGHT: clip_height_reg <= cfg_data;
                REG_OPACITY:     opacity_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // global advance: output register empty or being taken
    logic advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // ---------------- stage 1: factor and clip ----------------
    logic [7:0]  in_src [NUM_LANES];
    logic [7:0]  in_dst [NUM_LANES];
    logic [11:0] in_col, in_row;

    assign in_src[0] = s_tdata[7:0];
    assign in_src[1] = s_tdata[15:8];
    assign in_src[2] = s_tdata[23:16];
    assign in_src[3] = 8'hff;           // alpha blends towards full
    assign in_dst[0] = s_tdata[39:32];
    assign in_dst[1] = s_tdata[47:40];
    assign in_dst[2] = s_tdata[55:48];
    assign in_dst[3] = s_tdata[63:56];
    assign in_col    = s_tdata[75:64];
    assign in_row    = s_tdata[87:76];

    logic signed [13:0] px_w, py_w;
    logic [13:0]        clip_right_w, clip_bottom_w;
    logic               in_x_w, in_y_w;

    assign px_w = {dest_x_reg[12], dest_x_reg} + $signed({2'b00, in_col});
    assign py_w = {dest_y_reg[12], dest_y_reg} + $signed({2'b00, in_row});
    assign clip_right_w  = {1'b0, clip_left_reg} + {1'b0, clip_width_reg};
    assign clip_bottom_w = {1'b0, clip_top_reg} + {1'b0, clip_height_reg};

    // negative positions never reach the clip
    assign in_x_w = !px_w[13] && (px_w[12:0] >= clip_left_reg)
                 && ({1'b0, px_w[12:0]} < clip_right_w)
                 && (px_w[12:0] < 13'(MAX_DIM));
    assign in_y_w = !py_w[13] && (py_w[12:0] >= clip_top_reg)
                 && ({1'b0, py_w[12:0]} < clip_bottom_w)
                 && (py_w[12:0] < 13'(MAX_DIM));

    logic        v1_reg;
    logic [15:0] f1_reg;
    logic [7:0]  s1_reg [NUM_LANES];
    logic [7:0]  d1_reg [NUM_LANES];
    logic        wr1_reg;
    logic [11:0] px1_reg, py1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            f1_reg  <= opacity_reg * s_tdata[31:24];
            s1_reg  <= in_src;
            d1_reg  <= in_dst;
            wr1_reg <= in_x_w && in_y_w;
            px1_reg <= (in_x_w && in_y_w) ? px_w[11:0] : 12'd0;
            py1_reg <= (in_x_w && in_y_w) ? py_w[11:0] : 12'd0;
        end
    end

    // ---------------- stage 2: m = 2*(d*65025 + (s-d)*f) + 65025 ----------------
    logic [24:0] m_next [NUM_LANES];

    always_comb begin
        logic signed [8:0]  diff;
        logic signed [25:0] prod;
        logic [23:0]        dterm;
        logic signed [26:0] n_full;
        for (int i = 0; i < NUM_LANES; i++) begin
            diff   = $signed({1'b0, s1_reg[i]}) - $signed({1'b0, d1_reg[i]});
            prod   = diff * $signed({1'b0, f1_reg});
            dterm  = d1_reg[i] * 16'(FULL_SCALE);
            n_full = $signed({3'b000, dterm}) + {prod[25], prod};
            m_next[i] = {n_full[23:0], 1'b0} + 25'(FULL_SCALE);
        end
    end

    logic        v2_reg;
    logic [24:0] m2_reg [NUM_LANES];
    logic        wr2_reg;
    logic [11:0] px2_reg, py2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m2_reg  <= m_next;
            wr2_reg <= wr1_reg;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
    end

    // ---------------- stage 3: quotient estimate by reciprocal ----------------
    logic [7:0] q0_next [NUM_LANES];

    always_comb begin
        logic [40:0] rp;
        for (int i = 0; i < NUM_LANES; i++) begin
            rp = m2_reg[i] * RECIP;
            q0_next[i] = rp[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    logic        v3_reg;
    logic [7:0]  q03_reg [NUM_LANES];
    logic [24:0] m3_reg  [NUM_LANES];
    logic        wr3_reg;
    logic [11:0] px3_reg, py3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (advance) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            q03_reg <= q0_next;
            m3_reg  <= m2_reg;
            wr3_reg <= wr2_reg;
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
        end
    end

    // ---------------- stage 4: remainder check, output register ----------------
    logic [25:0] rem_w [NUM_LANES];
    logic [7:0]  q_next [NUM_LANES];

    always_comb begin
        logic [24:0] qd;
        for (int i = 0; i < NUM_LANES; i++) begin
            qd       = q03_reg[i] * 17'(DOUBLE_SCALE);
            rem_w[i] = {1'b0, m3_reg[i]} - {1'b0, qd};
            // estimate is at most one short
            q_next[i] = q03_reg[i] + 8'(rem_w[i] >= 26'(DOUBLE_SCALE));
        end
    end

    logic        out_valid_reg;
    logic [7:0]  out_ch_reg [NUM_LANES];
    logic        out_wr_reg;
    logic [11:0] out_px_reg, out_py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ch_reg <= q_next;
            out_wr_reg <= wr3_reg;
            out_px_reg <= px3_reg;
            out_py_reg <= py3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_py_reg, out_px_reg,
                       out_ch_reg[3], out_ch_reg[2], out_ch_reg[1], out_ch_reg[0]};
    assign m_tuser  = out_wr_reg;

    // ---------------- checks ----------------
    // position is zeroed whenever the word is not to be written
    a_pos_zero_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[55:32] == 24'd0)
        else $error("position not cleared outside clip");

    // reciprocal estimate never more than one short
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (rem_w[0] < 26'(2 * DOUBLE_SCALE)) && (rem_w[1] < 26'(2 * DOUBLE_SCALE))
                && (rem_w[2] < 26'(2 * DOUBLE_SCALE)) && (rem_w[3] < 26'(2 * DOUBLE_SCALE)))
        else $error("quotient correction out of range");

    // an accepted word reaches the output once each later stage has advanced without a stall
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 advance ##1 advance ##1 advance |=> m_tvalid)
        else $error("word lost in pipeline");

    // when the output holds, the stage behind it holds too
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(v3_reg) && $stable(q03_reg[0]))
        else $error("pipeline moved during stall");

endmodule

// ----- test/tb_clipped_alpha_compose_top.sv -----
// Testbench for the clipped alpha compositor: directed and random pixels, scoreboard check.
`timescale 1ns / 1ps

module tb_clipped_alpha_compose_top;
    import cac_pkg::*;

    localparam int PIX_SCALE   = 65025;
    localparam int CANVAS      = 4096;
    localparam int STALL_LIMIT = 2000;

    // packed msb first, so the last member lands in the lowest bits
    typedef struct packed {
        logic [11:0] src_row;
        logic [11:0] src_col;
        logic [7:0]  dst_alpha;
        logic [7:0]  dst_blue;
        logic [7:0]  dst_green;
        logic [7:0]  dst_red;
        logic [7:0]  src_alpha;
        logic [7:0]  src_blue;
        logic [7:0]  src_green;
        logic [7:0]  src_red;
    } pixel_word_t;

    typedef struct packed {
        logic [11:0] pos_y;
        logic [11:0] pos_x;
        logic [7:0]  out_alpha;
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
    } blend_word_t;

    typedef struct {
        blend_word_t word;
        logic        write_enable;
    } blend_result_t;

    class blend_scoreboard;
        int            dest_x;
        int            dest_y;
        int            clip_left;
        int            clip_top;
        int            clip_width;
        int            clip_height;
        logic [7:0]    opacity;
        blend_result_t expected_blends[$];
        int            errors;

        function new();
            dest_x      = 0;
            dest_y      = 0;
            clip_left   = 0;
            clip_top    = 0;
            clip_width  = 4096;
            clip_height = 4096;
            opacity     = 8'd255;
            errors      = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [12:0] v);
            case (idx)
                REG_DEST_X:      dest_x = int'($signed(v));
                REG_DEST_Y:      dest_y = int'($signed(v));
                REG_CLIP_LEFT:   clip_left = int'(v);
                REG_CLIP_TOP:    clip_top = int'(v);
                REG_CLIP_WIDTH:  clip_width = int'(v);
                REG_CLIP_HEIGHT: clip_height = int'(v);
                REG_OPACITY:     opacity = v[7:0];
                default: ;
            endcase
        endfunction

        // exact source-over mix, rounded half up
        function logic [7:0] mix(logic [7:0] d, logic [7:0] s, logic [15:0] f);
            logic [31:0] num;
            num = 32'(d) * (32'(PIX_SCALE) - 32'(f)) + 32'(s) * 32'(f);
            return 8'((2 * num + 32'(PIX_SCALE)) / (2 * 32'(PIX_SCALE)));
        endfunction

        function bit in_span(int p, int lo, int len);
            return p >= lo && p < lo + len && p < CANVAS;
        endfunction

        function blend_result_t predict_blend(pixel_word_t p);
            blend_result_t r;
            logic [15:0]   f;
            int            px;
            int            py;
            f  = 16'(opacity) * 16'(p.src_alpha);
            px = dest_x + int'(p.src_col);
            py = dest_y + int'(p.src_row);
            r.word.out_red   = mix(p.dst_red, p.src_red, f);
            r.word.out_green = mix(p.dst_green, p.src_green, f);
            r.word.out_blue  = mix(p.dst_blue, p.src_blue, f);
            r.word.out_alpha = mix(p.dst_alpha, 8'd255, f);
            r.write_enable   = in_span(px, clip_left, clip_width) &&
                               in_span(py, clip_top, clip_height);
            r.word.pos_x     = r.write_enable ? px[11:0] : 12'd0;
            r.word.pos_y     = r.write_enable ? py[11:0] : 12'd0;
            return r;
        endfunction

        function void note_pixel(pixel_word_t p);
            expected_blends.push_back(predict_blend(p));
        endfunction

        function void check_word(blend_word_t got, logic got_we);
            blend_result_t want;
            if (expected_blends.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: rgba %h %h %h %h pos (%0d,%0d) we %b",
                             got.out_red, got.out_green, got.out_blue, got.out_alpha,
                             got.pos_x, got.pos_y, got_we);
                return;
            end
            want = expected_blends.pop_front();
            if (got.out_red !== want.word.out_red || got.out_green !== want.word.out_green
                    || got.out_blue !== want.word.out_blue
                    || got.out_alpha !== want.word.out_alpha
                    || got.pos_x !== want.word.pos_x || got.pos_y !== want.word.pos_y
                    || got_we !== want.write_enable) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp rgba %h %h %h %h pos (%0d,%0d) we %b, got rgba %h %h %h %h pos (%0d,%0d) we %b",
                             want.word.out_red, want.word.out_green, want.word.out_blue,
                             want.word.out_alpha, want.word.pos_x, want.word.pos_y,
                             want.write_enable, got.out_red, got.out_green, got.out_blue,
                             got.out_alpha, got.pos_x, got.pos_y, got_we);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic [87:0]           s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [55:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blend_scoreboard sb;
    int              src_idle_max  = 15;
    int              sink_idle_max = 15;
    int              quiet_cycles  = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    clipped_alpha_compose_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watchdog: cycles without any word moving on any channel
    always @(posedge aclk) begin
        if ((s_tvalid & s_tready) === 1'b1 || (m_tvalid & m_tready) === 1'b1
                || (cfg_valid & cfg_ready) === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result sink with random back-pressure
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, sink_idle_max);
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_word(blend_word_t'(m_tdata), m_tuser[0]);
        end
    end

    task automatic write_reg(cfg_reg_t idx, int val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(val);
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.set_reg(idx, 13'(val));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int dx, int dy, int cl, int ct, int cw, int ch, int op);
        write_reg(REG_DEST_X, dx);
        write_reg(REG_DEST_Y, dy);
        write_reg(REG_CLIP_LEFT, cl);
        write_reg(REG_CLIP_TOP, ct);
        write_reg(REG_CLIP_WIDTH, cw);
        write_reg(REG_CLIP_HEIGHT, ch);
        write_reg(REG_OPACITY, op);
    endtask

    // valid stays up across back-to-back words
    task automatic push_pixel(pixel_word_t p);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_pixel(p);
    endtask

    // drop valid and let the pipe empty before touching config
    task automatic end_burst();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_blends.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic pixel_word_t make_px(int sr, int sg, int sbl, int sa, int dr, int dg,
                                            int dbl, int da, int col, int row);
        pixel_word_t p;
        p.src_red   = 8'(sr);
        p.src_green = 8'(sg);
        p.src_blue  = 8'(sbl);
        p.src_alpha = 8'(sa);
        p.dst_red   = 8'(dr);
        p.dst_green = 8'(dg);
        p.dst_blue  = 8'(dbl);
        p.dst_alpha = 8'(da);
        p.src_col   = 12'(col);
        p.src_row   = 12'(row);
        return p;
    endfunction

    function automatic int pick_level();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            2: return $urandom_range(0, 1) ? 1 : 254;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // source coordinate that lands near the clip window edges most of the time
    function automatic int aim_coord(int origin, int lo, int len);
        int c;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 4095);
        c = lo - 4 + $urandom_range(0, len + 8) - origin;
        if (c < 0)
            c = $urandom_range(0, 7);
        if (c > 4095)
            c = 4095 - $urandom_range(0, 7);
        return c;
    endfunction

    function automatic pixel_word_t random_pixel();
        return make_px(pick_level(), pick_level(), pick_level(), pick_level(),
                       pick_level(), pick_level(), pick_level(), pick_level(),
                       aim_coord(sb.dest_x, sb.clip_left, sb.clip_width),
                       aim_coord(sb.dest_y, sb.clip_top, sb.clip_height));
    endfunction

    task automatic random_window();
        int dx;
        int dy;
        int cl;
        int ct;
        int cw;
        int ch;
        int op;
        dx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) - 4096
                                         : $urandom_range(0, 128) - 64;
        dy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) - 4096
                                         : $urandom_range(0, 128) - 64;
        cl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 64);
        ct = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 64);
        case ($urandom_range(0, 7))
            0: cw = 0;
            1: cw = 4096;
            default: cw = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 7))
            0: ch = 0;
            1: ch = 4096;
            default: ch = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 2))
            0: op = 0;
            1: op = 255;
            default: op = $urandom_range(0, 255);
        endcase
        set_window(dx, dy, cl, ct, cw, ch, op);
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_DEST_X;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset window: whole canvas, opaque
        push_pixel(make_px(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_pixel(make_px(255, 255, 255, 255, 0, 0, 0, 0, 4095, 4095));
        push_pixel(make_px(12, 200, 99, 255, 250, 3, 77, 40, 1, 2));
        push_pixel(make_px(200, 100, 50, 0, 10, 20, 30, 40, 7, 9));
        push_pixel(make_px(255, 0, 255, 128, 0, 255, 0, 127, 4094, 1));
        push_pixel(make_px('haa, 'h55, 'haa, 1, 'h55, 'haa, 'h55, 'haa, 'haaa, 'h555));
        push_pixel(make_px('h55, 'haa, 'h55, 254, 'haa, 'h55, 'haa, 'h55, 'h555, 'haaa));
        end_burst();

        // negative placement, zero opacity
        set_window(-4096, -1, 0, 0, 4096, 4096, 0);
        push_pixel(make_px(255, 255, 255, 255, 0, 0, 0, 0, 4095, 1));
        push_pixel(make_px(9, 8, 7, 255, 1, 2, 3, 4, 4095, 0));
        end_burst();

        // clip running past the canvas edge
        set_window(4095, 4095, 4000, 4000, 4096, 4096, 128);
        push_pixel(make_px(255, 128, 0, 200, 0, 128, 255, 50, 0, 0));
        push_pixel(make_px(255, 128, 0, 200, 0, 128, 255, 50, 1, 0));
        push_pixel(make_px(255, 128, 0, 200, 0, 128, 255, 50, 0, 4095));
        end_burst();
        set_window(0, 0, 4096, 0, 4096, 4096, 255);
        push_pixel(make_px(1, 2, 3, 4, 5, 6, 7, 8, 4095, 0));
        end_burst();

        // empty clip in each axis, then a single-pixel clip
        set_window(0, 0, 10, 10, 0, 50, 255);
        push_pixel(make_px(60, 70, 80, 90, 100, 110, 120, 130, 10, 20));
        end_burst();
        set_window(0, 0, 10, 10, 50, 0, 255);
        push_pixel(make_px(60, 70, 80, 90, 100, 110, 120, 130, 10, 20));
        end_burst();
        set_window(0, 0, 10, 10, 1, 1, 77);
        push_pixel(make_px(60, 70, 80, 90, 100, 110, 120, 130, 10, 10));
        push_pixel(make_px(60, 70, 80, 90, 100, 110, 120, 130, 11, 10));
        push_pixel(make_px(60, 70, 80, 90, 100, 110, 120, 130, 9, 10));
        end_burst();

        for (int ph = 0; ph < 11; ph++) begin
            src_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 15;
            sink_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
            random_window();
            repeat (48) push_pixel(random_pixel());
            end_burst();
        end

        if (sb.expected_blends.size() != 0)
            sb.errors++;
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/cac_pkg.sv
hdl/clipped_alpha_compose_top.sv
test/tb_clipped_alpha_compose_top.sv
